/* design/pwnms_pkg.sv */
// Shared types, constants and helpers of the Prewitt edge / NMS core.
`default_nettype none
package pwnms_pkg;

    localparam int unsigned MaxWidthDef  = 1024;
    localparam int unsigned MaxHeightDef = 1024;
    localparam int unsigned WidthReset   = 640;
    localparam int unsigned HeightReset  = 480;
    localparam int unsigned MinSize      = 3;
    localparam int unsigned CfgDataW     = 11;
    localparam int unsigned CfgIndexW    = 8;
    localparam int unsigned TanLowQ8     = 106;
    localparam int unsigned TanHighQ8    = 618;

    localparam logic [CfgIndexW-1:0] CfgImageWidth  = CfgIndexW'(0);
    localparam logic [CfgIndexW-1:0] CfgImageHeight = CfgIndexW'(1);

    typedef enum logic [1:0] {
        DirHorizontal = 2'd0,
        DirVertical   = 2'd1,
        DirNegDiag    = 2'd2,
        DirPosDiag    = 2'd3
    } t_dir;

    typedef struct packed {
        t_dir       dir;
        logic [7:0] mag;
        logic [7:0] pix;
    } t_line;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
        int unsigned r;
        r = v;
        if (v < MinSize) r = MinSize;
        else if (v > hi) r = hi;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/pwnms_ram.sv */
// Generic simple dual-port RAM, one write port, registered read port.
`default_nettype none
module pwnms_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/pwnms_sqrt.sv */
// Iterative saturating integer square root, one result bit per cycle.
`default_nettype none
module pwnms_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [20:0] i_value,
    output logic             o_done,
    output logic [7:0]       o_root
);
    logic [15:0] r_s;
    logic        r_sat;
    logic [7:0]  r_r;
    logic [7:0]  r_bit;
    logic        r_done;
    logic [7:0]  trial;
    logic [15:0] trial_sq;

    assign trial    = r_r | r_bit;
    assign trial_sq = 16'(trial) * 16'(trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_bit <= 8'h80;
            end else if (|r_bit) begin
                r_bit  <= r_bit >> 1;
                r_done <= r_bit[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s   <= i_value[15:0];
            r_sat <= |i_value[20:16];
            r_r   <= '0;
        end else if ((|r_bit) && (trial_sq <= r_s)) begin
            r_r <= trial;
        end
    end

    assign o_done = r_done;
    assign o_root = r_sat ? 8'hFF : r_r;
endmodule
`default_nettype wire

/* design/prewitt_edge_nms_core.sv */
// Top level: Prewitt gradient magnitude with non-maximum suppression.
//
//  channel  | direction | transfer when             | payload
//  s_axis   | in        | s_axis_tvalid&tready      | tdata pixel, tuser start/padding
//  m_axis   | out       | m_axis_tvalid&tready      | tdata magnitudes, tlast frame end
//  cfg      | in        | i_cfg_valid&o_cfg_ready   | i_cfg_index, i_cfg_data
//
// The next input transfer waits until the pixel has passed all steps and any output
// stall: accept, two line-RAM reads, window load, sums, squares, the bit-serial
// square root, write-back, suppression. A dropped padding transfer leaves the
// core idle. A size write offered with a pixel goes first.
// Reset returns sizes to 640x480 and the position to zero; RAM is not cleared.
// A held result blocks only the final stage of the next pixel.
`default_nettype none
module prewitt_edge_nms_core #(
    parameter int unsigned MAX_WIDTH  = pwnms_pkg::MaxWidthDef,
    parameter int unsigned MAX_HEIGHT = pwnms_pkg::MaxHeightDef
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,  // [7:0] pixel
    input  wire logic [1:0]                     s_axis_tuser,  // [0] frame_start, [1] padding
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [7:0] gradient, [15:8] suppressed
    output logic                                m_axis_tlast,  // frame_end
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [pwnms_pkg::CfgIndexW-1:0] i_cfg_index,
    input  wire logic [pwnms_pkg::CfgDataW-1:0]  i_cfg_data
);
    localparam int unsigned ColW  = $clog2(MAX_WIDTH);
    localparam int unsigned XW    = ColW + 1;
    localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 3);
    localparam int unsigned YW    = RowW + 1;
    localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
    localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned RamD  = 2 * (1 << ColW);
    localparam int unsigned LineW = $bits(pwnms_pkg::t_line);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_GRAD = 9'b000001000,
        S_SUM  = 9'b000010000,
        S_SQ   = 9'b000100000,
        S_SQRT = 9'b001000000,
        S_WR   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [WW-1:0]   r_w;
    logic [HW-1:0]   r_h;
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;
    logic [7:0]      r_pix;
    pwnms_pkg::t_line r_line_a, r_line_b;
    logic [7:0]      r_pw [3][3];
    logic [7:0]      r_mw [3][3];
    logic [9:0]      r_ax, r_ay;
    logic            r_sgn_diff;
    pwnms_pkg::t_dir r_dnew, r_dprev, r_dcent;
    logic            r_ovalid;
    logic [15:0]     r_odata;
    logic            r_olast;

    logic            s_xfer, m_xfer, cfg_xfer, start_eff;
    logic [RowW-1:0] row_eff;
    logic [YW-1:0]   row_x, h_x;
    logic [XW-1:0]   col_x, w_x;
    logic            ignore, emit, fend, gint, qint, out_ok;
    logic            sq_done;
    logic [7:0]      sq_root;
    logic [20:0]     sum_sq;
    logic [9:0]      sl, sr, st, sb;
    logic [10:0]     gx, gy;
    logic [19:0]     ax_q8, ay_lo, ay_hi;
    pwnms_pkg::t_line ram_rdata;
    logic [ColW:0]   ram_raddr, ram_waddr;
    pwnms_pkg::t_line wr_line;
    logic [7:0]      nb_a, nb_b, cen, new_mag;

    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign m_xfer   = r_ovalid && m_axis_tready;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;
    assign start_eff = s_axis_tuser[0] && !s_axis_tuser[1];
    assign row_eff  = start_eff ? '0 : r_row;
    assign ignore   = s_axis_tuser[1] && (YW'(row_eff) < YW'(r_h));

    assign row_x = YW'(r_row);
    assign h_x   = YW'(r_h);
    assign col_x = XW'(r_col);
    assign w_x   = XW'(r_w);
    assign emit  = (row_x >= YW'(3)) || ((row_x == YW'(2)) && (col_x >= XW'(2)));
    assign fend  = (row_x == h_x + YW'(2)) && (col_x == XW'(1));
    assign gint  = (col_x >= XW'(2)) && (row_x >= YW'(2)) && (row_x < h_x);
    assign qint  = ((col_x >= XW'(3)) && (row_x >= YW'(3)) && (row_x <= h_x)) ||
                   ((col_x == XW'(0)) && (row_x >= YW'(4)) && (row_x <= h_x + YW'(1)));
    assign out_ok = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

    // line RAM: entry {row parity, column}
    assign ram_raddr = (r_state == S_RDA) ? {~r_row[0], r_col} : {r_row[0], r_col};
    assign ram_waddr = {r_row[0], r_col};
    assign new_mag   = gint ? sq_root : 8'd0;
    assign wr_line   = '{dir: (gint ? r_dnew : pwnms_pkg::DirHorizontal),
                         mag: new_mag, pix: r_pix};

    pwnms_ram #(.Width(LineW), .Depth(RamD)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (ram_waddr),
        .i_wdata (wr_line),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign sum_sq = 21'(r_ax) * 21'(r_ax) + 21'(r_ay) * 21'(r_ay);

    pwnms_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQ),
        .i_value (sum_sq),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign sl = 10'(r_pw[0][0]) + 10'(r_pw[1][0]) + 10'(r_pw[2][0]);
    assign sr = 10'(r_pw[0][2]) + 10'(r_pw[1][2]) + 10'(r_pw[2][2]);
    assign st = 10'(r_pw[0][0]) + 10'(r_pw[0][1]) + 10'(r_pw[0][2]);
    assign sb = 10'(r_pw[2][0]) + 10'(r_pw[2][1]) + 10'(r_pw[2][2]);
    assign gx = 11'(sr) - 11'(sl);
    assign gy = 11'(sb) - 11'(st);

    assign ax_q8 = {2'b00, r_ax, 8'd0};
    assign ay_lo = 20'(r_ay) * 20'(pwnms_pkg::TanLowQ8);
    assign ay_hi = 20'(r_ay) * 20'(pwnms_pkg::TanHighQ8);

    assign cen = r_mw[1][1];
    always_comb begin
        case (r_dcent)
            pwnms_pkg::DirHorizontal: begin nb_a = r_mw[0][1]; nb_b = r_mw[2][1]; end
            pwnms_pkg::DirVertical:   begin nb_a = r_mw[1][0]; nb_b = r_mw[1][2]; end
            pwnms_pkg::DirNegDiag:    begin nb_a = r_mw[0][2]; nb_b = r_mw[2][0]; end
            default:                  begin nb_a = r_mw[2][2]; nb_b = r_mw[0][0]; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (s_xfer && !ignore) n_state = S_RDA;
            S_RDA:  n_state = S_RDB;
            S_RDB:  n_state = S_GRAD;
            S_GRAD: n_state = S_SUM;
            S_SUM:  n_state = S_SQ;
            S_SQ:   n_state = S_SQRT;
            S_SQRT: if (sq_done) n_state = S_WR;
            S_WR:   n_state = S_OUT;
            S_OUT:  if (!emit || out_ok) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_w      <= WW'(pwnms_pkg::clamp_size(pwnms_pkg::WidthReset, MAX_WIDTH));
            r_h      <= HW'(pwnms_pkg::clamp_size(pwnms_pkg::HeightReset, MAX_HEIGHT));
            r_row    <= '0;
            r_col    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && emit && out_ok) r_ovalid <= 1'b1;
            else if (m_xfer) r_ovalid <= 1'b0;
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    pwnms_pkg::CfgImageWidth: begin
                        r_w   <= WW'(pwnms_pkg::clamp_size(32'(i_cfg_data), MAX_WIDTH));
                        r_row <= '0;
                        r_col <= '0;
                    end
                    pwnms_pkg::CfgImageHeight: begin
                        r_h   <= HW'(pwnms_pkg::clamp_size(32'(i_cfg_data), MAX_HEIGHT));
                        r_row <= '0;
                        r_col <= '0;
                    end
                    default: ;
                endcase
            end
            if (s_xfer) begin
                r_row <= row_eff;
                if (start_eff) r_col <= '0;
            end
            if ((r_state == S_OUT) && (!emit || out_ok)) begin
                if (emit && fend) begin
                    r_row <= '0;
                    r_col <= '0;
                end else if (col_x + XW'(1) >= w_x) begin
                    r_col <= '0;
                    r_row <= r_row + RowW'(1);
                end else begin
                    r_col <= r_col + ColW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) r_pix <= s_axis_tdata;
        if (r_state == S_RDB) r_line_a <= ram_rdata;
        if (r_state == S_GRAD) begin
            r_line_b <= ram_rdata;
            for (int i = 0; i < 3; i++) begin
                r_pw[i][0] <= r_pw[i][1];
                r_pw[i][1] <= r_pw[i][2];
            end
            r_pw[0][2] <= ram_rdata.pix;
            r_pw[1][2] <= r_line_a.pix;
            r_pw[2][2] <= r_pix;
        end
        if (r_state == S_SUM) begin
            r_ax       <= gx[10] ? 10'(-gx) : gx[9:0];
            r_ay       <= gy[10] ? 10'(-gy) : gy[9:0];
            r_sgn_diff <= gx[10] != gy[10];
        end
        if (r_state == S_SQ) begin
            if (ax_q8 <= ay_lo)      r_dnew <= pwnms_pkg::DirHorizontal;
            else if (ax_q8 >= ay_hi) r_dnew <= pwnms_pkg::DirVertical;
            else if (r_sgn_diff)     r_dnew <= pwnms_pkg::DirNegDiag;
            else                     r_dnew <= pwnms_pkg::DirPosDiag;
        end
        if (r_state == S_WR) begin
            for (int i = 0; i < 3; i++) begin
                r_mw[i][0] <= r_mw[i][1];
                r_mw[i][1] <= r_mw[i][2];
            end
            r_mw[0][2] <= r_line_b.mag;
            r_mw[1][2] <= r_line_a.mag;
            r_mw[2][2] <= new_mag;
            r_dcent    <= r_dprev;
            r_dprev    <= r_line_a.dir;
        end
        if ((r_state == S_OUT) && emit && out_ok) begin
            r_odata[7:0]  <= qint ? cen : 8'd0;
            r_odata[15:8] <= (qint && !(nb_a > cen) && !(nb_b > cen)) ? cen : 8'd0;
            r_olast       <= fend;
        end
    end

    a_sqrt_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_SQRT))
        else $error("root finished outside its wait state");

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_x < w_x)
        else $error("column position beyond image width");

    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && emit && fend && out_ok) |=>
            ((r_row == '0) && (r_col == '0) && r_ovalid && r_olast))
        else $error("frame end did not restart position");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_xfer && ((i_cfg_index == pwnms_pkg::CfgImageWidth) ||
                      (i_cfg_index == pwnms_pkg::CfgImageHeight)))
        |=> ((r_row == '0) && (r_col == '0)))
        else $error("size write did not restart position");
endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the Prewitt edge / non-maximum suppression core.
`default_nettype none
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RingDepth  = 4 * pwnms_pkg::MaxWidthDef + 8;
    localparam int unsigned CycleLimit = 3000000;
    localparam int unsigned Settle     = 40;
    localparam int unsigned HoldCycles = 400;
    localparam int unsigned RandItems  = 1000;
    localparam logic [pwnms_pkg::CfgIndexW-1:0] CfgUnused = pwnms_pkg::CfgIndexW'(2);

    typedef enum int {ImgNoise, ImgRamp, ImgStep, ImgFlat} t_img;

    typedef struct {
        logic [7:0] grad;
        logic [7:0] supp;
        logic       last;
    } t_edge_px;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] pixel
    logic [1:0] s_axis_tuser = '0;   // [0] frame_start, [1] padding
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;       // [7:0] gradient, [15:8] suppressed
    logic m_axis_tlast;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [pwnms_pkg::CfgIndexW-1:0] i_cfg_index = '0;
    logic [pwnms_pkg::CfgDataW-1:0] i_cfg_data = '0;

    prewitt_edge_nms_core dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [pwnms_pkg::CfgDataW-1:0] width_reg = pwnms_pkg::CfgDataW'(pwnms_pkg::WidthReset);
    logic [pwnms_pkg::CfgDataW-1:0] height_reg = pwnms_pkg::CfgDataW'(pwnms_pkg::HeightReset);
    logic [7:0] pix_ring [RingDepth];
    logic [7:0] mag_ring [RingDepth];
    pwnms_pkg::t_dir dir_ring [RingDepth];
    int unsigned in_row = 0, in_col = 0;

    t_edge_px expected_px[$];
    int unsigned mismatches = 0, results_seen = 0, items_sent = 0, frames_done = 0;
    int unsigned cycles = 0;
    int unsigned hold_left = 0;
    bit hold_req = 0, steady = 0;

    function automatic int unsigned fit(input int unsigned v, input int unsigned hi);
        return (v < pwnms_pkg::MinSize) ? pwnms_pkg::MinSize : (v > hi) ? hi : v;
    endfunction

    function automatic int unsigned sqrt_sat(input int unsigned s);
        int unsigned r;
        r = 0;
        if (s >= 65536) return 255;
        for (int unsigned b = 128; b != 0; b >>= 1)
            if ((r + b) * (r + b) <= s) r += b;
        return r;
    endfunction

    task automatic gradient_at(input int unsigned m, input int unsigned w,
                               input int unsigned h);
        int unsigned r, c, ax, ay, mag;
        int v [3][3];
        int gx, gy;
        pwnms_pkg::t_dir d;
        r = m / w;
        c = m % w;
        mag = 0;
        d = pwnms_pkg::DirHorizontal;
        if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    v[i][j] = pix_ring[(m - w - 1 + i * w + j) % RingDepth];
            gx = (v[0][2] + v[1][2] + v[2][2]) - (v[0][0] + v[1][0] + v[2][0]);
            gy = (v[2][0] + v[2][1] + v[2][2]) - (v[0][0] + v[0][1] + v[0][2]);
            mag = sqrt_sat(gx * gx + gy * gy);
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            if (256 * ax <= pwnms_pkg::TanLowQ8 * ay) d = pwnms_pkg::DirHorizontal;
            else if (256 * ax >= pwnms_pkg::TanHighQ8 * ay) d = pwnms_pkg::DirVertical;
            else if ((gx < 0) != (gy < 0)) d = pwnms_pkg::DirNegDiag;
            else d = pwnms_pkg::DirPosDiag;
        end
        mag_ring[m % RingDepth] = mag[7:0];
        dir_ring[m % RingDepth] = d;
    endtask

    task automatic predict_edges(input logic [7:0] pix, input bit start, input bit pad);
        int unsigned w, h, total, p, q, cen, nms, r, c, a, b;
        t_edge_px e;
        w = fit(width_reg, pwnms_pkg::MaxWidthDef);
        h = fit(height_reg, pwnms_pkg::MaxHeightDef);
        total = w * h;
        if (!pad && start) begin in_row = 0; in_col = 0; end
        if (in_col >= w) begin in_row = 0; in_col = 0; end
        p = in_row * w + in_col;
        if (p >= total + 2 * w + 2) begin in_row = 0; in_col = 0; p = 0; end
        if (pad && p < total) return;
        if (p < total) pix_ring[p % RingDepth] = pix;
        if (p >= w + 1) gradient_at(p - w - 1, w, h);
        if (p >= 2 * w + 2) begin
            q = p - 2 * w - 2;
            cen = mag_ring[q % RingDepth];
            nms = 0;
            r = q / w;
            c = q % w;
            if (r >= 1 && r + 1 < h && c >= 1 && c + 1 < w) begin
                case (dir_ring[q % RingDepth])
                    pwnms_pkg::DirHorizontal: begin a = q - w; b = q + w; end
                    pwnms_pkg::DirVertical: begin a = q - 1; b = q + 1; end
                    pwnms_pkg::DirNegDiag: begin a = q - w + 1; b = q + w - 1; end
                    default: begin a = q + w + 1; b = q - w - 1; end
                endcase
                nms = (mag_ring[a % RingDepth] > cen || mag_ring[b % RingDepth] > cen)
                      ? 0 : cen;
            end
            e.grad = cen[7:0];
            e.supp = nms[7:0];
            e.last = (q == total - 1);
            expected_px.push_back(e);
            if (e.last) begin
                in_row = 0;
                in_col = 0;
                frames_done++;
                return;
            end
        end
        in_col++;
        if (in_col >= w) begin in_col = 0; in_row++; end
    endtask

    task automatic send_pixel(input logic [7:0] pix, input bit start, input bit pad);
        while (!steady && $urandom_range(99) < 29) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tuser <= 2'($urandom);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        s_axis_tuser <= {pad, start};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_edges(pix, start, pad);
        items_sent++;
    endtask

    task automatic write_reg(input logic [pwnms_pkg::CfgIndexW-1:0] idx,
                             input logic [pwnms_pkg::CfgDataW-1:0] val);
        s_axis_tvalid <= 1'b0;
        wait (expected_px.size() == 0);
        repeat (Settle) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == pwnms_pkg::CfgImageWidth) width_reg = val;
        else if (idx == pwnms_pkg::CfgImageHeight) height_reg = val;
        else return;
        in_row = 0;
        in_col = 0;
    endtask

    function automatic logic [7:0] image_px(input t_img kind, input int r, input int c,
                                            input int base, input int sx, input int sy);
        case (kind)
            ImgNoise: return 8'($urandom);
            ImgRamp: return 8'(base + sx * c + sy * r);
            ImgStep: return (sx * c + sy * r > base / 2) ? 8'hff : 8'h00;
            default: return 8'(base);
        endcase
    endfunction

    // One frame; noisy frames may carry stray padding, extra pixels or an early restart.
    task automatic send_frame(input t_img kind, input bit noisy);
        int unsigned w, h, cut;
        int base, sx, sy;
        w = fit(width_reg, pwnms_pkg::MaxWidthDef);
        h = fit(height_reg, pwnms_pkg::MaxHeightDef);
        base = $urandom_range(255);
        sx = int'($urandom_range(160)) - 80;
        sy = int'($urandom_range(160)) - 80;
        cut = (noisy && $urandom_range(9) == 0) ? $urandom_range(w * h - 1) : w * h;
        for (int unsigned i = 0; i < cut; i++) begin
            if (noisy && $urandom_range(19) == 0) send_pixel(8'($urandom), 1'($urandom), 1'b1);
            send_pixel(image_px(kind, i / w, i % w, base, sx, sy), i == 0, 1'b0);
        end
        if (cut < w * h) return;
        for (int unsigned i = 0; i < 2 * w + 2; i++)
            if (noisy && $urandom_range(15) == 0) send_pixel(8'($urandom), 1'b0, 1'b0);
            else send_pixel(8'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic test_directed();
        write_reg(pwnms_pkg::CfgImageWidth, 11'd4);
        write_reg(pwnms_pkg::CfgImageHeight, 11'd4);
        send_pixel(8'h00, 1'b1, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b1);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'h80, 1'b0, 1'b0);
        send_pixel(8'h00, 1'b0, 1'b0);
        send_pixel(8'hff, 1'b0, 1'b0);
        send_pixel(8'h7f, 1'b0, 1'b0);
        send_pixel(8'h01, 1'b0, 1'b0);
        for (int i = 0; i < 9; i++) send_pixel(8'h00, 1'b1, 1'b1);
        send_pixel(8'haa, 1'b0, 1'b0);
    endtask

    task automatic test_size_extremes();
        write_reg(pwnms_pkg::CfgImageWidth, 11'd0);
        write_reg(pwnms_pkg::CfgImageHeight, 11'd2);
        send_frame(ImgRamp, 1'b0);
        write_reg(CfgUnused, 11'd5);
        write_reg(pwnms_pkg::CfgImageWidth, 11'd40);
        write_reg(pwnms_pkg::CfgImageHeight, 11'd1);
        send_frame(ImgNoise, 1'b0);
        write_reg(pwnms_pkg::CfgImageWidth, 11'd3);
        write_reg(pwnms_pkg::CfgImageHeight, 11'd3);
        send_frame(ImgStep, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned stop_at;
        stop_at = items_sent + RandItems;
        while (items_sent < stop_at) begin
            if ($urandom_range(3) == 0) begin
                write_reg(pwnms_pkg::CfgImageWidth, 11'($urandom_range(12, 3)));
                write_reg(pwnms_pkg::CfgImageHeight, 11'($urandom_range(10, 3)));
            end
            send_frame(t_img'($urandom_range(3)), $urandom_range(3) == 0);
        end
    endtask

    task automatic test_backpressure();
        write_reg(pwnms_pkg::CfgImageWidth, 11'd9);
        write_reg(pwnms_pkg::CfgImageHeight, 11'd7);
        hold_req = 1;
        send_frame(ImgNoise, 1'b0);
        steady = 1;
        send_frame(ImgRamp, 1'b0);
        send_frame(ImgStep, 1'b0);
        steady = 0;
    endtask

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_px.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: data %h last %b",
                                               m_axis_tdata, m_axis_tlast);
            end else begin
                t_edge_px e;
                e = expected_px.pop_front();
                if (m_axis_tdata[7:0] !== e.grad || m_axis_tdata[15:8] !== e.supp
                    || m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected grad %h supp %h last %b, got %h %h %b",
                                 e.grad, e.supp, e.last, m_axis_tdata[7:0],
                                 m_axis_tdata[15:8], m_axis_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_size_extremes();
        test_backpressure();
        test_random_frames();
        s_axis_tvalid <= 1'b0;
        wait (expected_px.size() == 0);
        repeat (Settle) @(posedge i_clk);
        $display("sent %0d input transfers, checked %0d results over %0d complete frames",
                 items_sent, results_seen, frames_done);
        $display("sizes from the clamped 3x3 minimum to 40 columns, stalls, restarts, padding");
        if (mismatches == 0 && expected_px.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
design/pwnms_pkg.sv
design/pwnms_ram.sv
design/pwnms_sqrt.sv
design/prewitt_edge_nms_core.sv
test/testbench.sv
